### hw/rtl/sonar_sweep_object_grouper_core_macros.svh
// Assertion macros shared by the sonar sweep object grouper.
`ifndef SONAR_SWEEP_OBJECT_GROUPER_CORE_MACROS_SVH
`define SONAR_SWEEP_OBJECT_GROUPER_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SSOG_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SSOG_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/ssog_pkg.sv
package ssog_pkg;

    // Field widths.
    localparam int ECHO_W  = 15;
    localparam int ANGLE_W = 8;
    localparam int DIST_W  = 13;
    localparam int RANGE_W = 9;
    localparam int MISS_W  = 2;
    localparam int REC_W   = ANGLE_W + DIST_W;

    // Echo conversion, smoothing, grouping and park constants.
    localparam logic [ECHO_W-1:0] ECHO_TIMEOUT_US = 15'd30000;
    localparam logic [9:0]        ECHO_SCALE      = 10'd557;
    localparam logic [7:0]        WEIGHT_NEW      = 8'd179;
    localparam logic [7:0]        WEIGHT_OLD      = 8'd77;
    localparam logic [DIST_W-1:0] MIN_DIST_Q4     = 13'd32;
    localparam logic [DIST_W-1:0] GROUP_SPAN_Q4   = 13'd320;
    localparam logic [ANGLE_W-1:0] PARK_ANGLE     = 8'd90;

    // Result word kinds.
    localparam logic KIND_POS = 1'b0;
    localparam logic KIND_OBJ = 1'b1;

    // Configuration register indexes.
    typedef enum logic [2:0] {
        REG_MIN_ANGLE     = 3'd0,
        REG_MAX_ANGLE     = 3'd1,
        REG_MAX_RANGE     = 3'd2,
        REG_RED_ZONE      = 3'd3,
        REG_ALERT_ENABLE  = 3'd4,
        REG_SYSTEM_ENABLE = 3'd5
    } t_reg_idx;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic smooth;
        logic group;
        logic sweep;
        logic clr_idx;
        logic rd;
        logic end_clear;
        logic obj;
        logic pos;
        logic park;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic sweep_end;
        logic idx_lt;
        logic out_free;
    } t_dp_sts;

endpackage

### hw/rtl/sonar_sweep_object_grouper_core.sv
// Each echo word is loaded on accept, then smoothed, grouped and swept, and its position word is then loaded into
// the output register; when disabled, a park position word follows the load. At a sweep end each stored object
// takes one store read and one output load before the position word. A new echo word is accepted only once the
// last position word is loaded. Output stalls hold the sequence only while a result waits in the output register.
// Reset is synchronous, active low: control and configuration registers take their reset values (payload registers
// are not), the sweep restarts at angle 0 going up, and the object store keeps its content (only the count is cleared).
`include "sonar_sweep_object_grouper_core_macros.svh"

module sonar_sweep_object_grouper_core #(
    parameter int MAX_OBJECT_RECORDS = 20,
    parameter int MISS_TOLERANCE     = 3
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [4:0]                   paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [ssog_pkg::ECHO_W-1:0]  i_echo_us,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic                         o_kind,
    output logic [ssog_pkg::ANGLE_W-1:0] o_angle,
    output logic [ssog_pkg::DIST_W-1:0]  o_distance_q4,
    output logic                         o_red_zone,
    output logic                         o_last
);
    import ssog_pkg::*;

    logic [ANGLE_W-1:0] r_min_angle;
    logic [ANGLE_W-1:0] r_max_angle;
    logic [RANGE_W-1:0] r_max_range_cm;
    logic [RANGE_W-1:0] r_red_zone_cm;
    logic               r_alert_enable;
    logic               r_system_enable;
    logic               w_wr;
    t_reg_idx           w_idx;
    t_dp_cmd            w_cmd;
    t_dp_sts            w_sts;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite && pready;
    assign w_idx  = t_reg_idx'(paddr[4:2]);

    // Configuration register writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_angle     <= 8'd0;
            r_max_angle     <= 8'd180;
            r_max_range_cm  <= 9'd200;
            r_red_zone_cm   <= 9'd50;
            r_alert_enable  <= 1'b1;
            r_system_enable <= 1'b1;
        end else if (w_wr) begin
            unique case (w_idx)
                REG_MIN_ANGLE:     r_min_angle     <= pwdata[ANGLE_W-1:0];
                REG_MAX_ANGLE:     r_max_angle     <= pwdata[ANGLE_W-1:0];
                REG_MAX_RANGE:     r_max_range_cm  <= pwdata[RANGE_W-1:0];
                REG_RED_ZONE:      r_red_zone_cm   <= pwdata[RANGE_W-1:0];
                REG_ALERT_ENABLE:  r_alert_enable  <= pwdata[0];
                REG_SYSTEM_ENABLE: r_system_enable <= pwdata[0];
                default: begin
                end
            endcase
        end
    end

    // Register read back.
    always_comb begin
        unique case (w_idx)
            REG_MIN_ANGLE:     prdata = 32'(r_min_angle);
            REG_MAX_ANGLE:     prdata = 32'(r_max_angle);
            REG_MAX_RANGE:     prdata = 32'(r_max_range_cm);
            REG_RED_ZONE:      prdata = 32'(r_red_zone_cm);
            REG_ALERT_ENABLE:  prdata = 32'(r_alert_enable);
            REG_SYSTEM_ENABLE: prdata = 32'(r_system_enable);
            default:           prdata = '0;
        endcase
    end

    ssog_ctrl u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_system_enable (r_system_enable),
        .i_sts           (w_sts),
        .o_cmd           (w_cmd)
    );

    ssog_dp #(
        .MAX_OBJECT_RECORDS (MAX_OBJECT_RECORDS),
        .MISS_TOLERANCE     (MISS_TOLERANCE)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_sts          (w_sts),
        .i_min_angle    (r_min_angle),
        .i_max_angle    (r_max_angle),
        .i_max_range_cm (r_max_range_cm),
        .i_red_zone_cm  (r_red_zone_cm),
        .i_alert_enable (r_alert_enable),
        .i_echo_us      (i_echo_us),
        .i_ready        (i_ready),
        .o_valid        (o_valid),
        .o_kind         (o_kind),
        .o_angle        (o_angle),
        .o_distance_q4  (o_distance_q4),
        .o_red_zone     (o_red_zone),
        .o_last         (o_last)
    );

    // An object word is never the final word of an item.
    `SSOG_ASSERT_SAME(a_obj_not_last, o_valid && (o_kind == KIND_OBJ), !o_last, "object word marked last")
    // A position word closes the item and carries no distance or flag.
    `SSOG_ASSERT_SAME(a_pos_clean, o_valid && (o_kind == KIND_POS), o_last && (o_distance_q4 == '0) && !o_red_zone, "malformed position word")
    // One echo word at a time: ready drops right after an accept.
    `SSOG_ASSERT_NEXT(a_one_at_a_time, i_valid && o_ready, !o_ready, "ready held after accept")
endmodule

### hw/rtl/ssog_ram.sv
module ssog_ram #(
    parameter int WIDTH = 21,
    parameter int DEPTH = 20
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic                                   i_re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Single write port, registered read port that holds between reads.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

### hw/rtl/ssog_dp.sv
module ssog_dp #(
    parameter int MAX_OBJECT_RECORDS = 20,
    parameter int MISS_TOLERANCE     = 3
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  ssog_pkg::t_dp_cmd            i_cmd,
    output ssog_pkg::t_dp_sts            o_sts,
    input  logic [ssog_pkg::ANGLE_W-1:0] i_min_angle,
    input  logic [ssog_pkg::ANGLE_W-1:0] i_max_angle,
    input  logic [ssog_pkg::RANGE_W-1:0] i_max_range_cm,
    input  logic [ssog_pkg::RANGE_W-1:0] i_red_zone_cm,
    input  logic                         i_alert_enable,
    input  logic [ssog_pkg::ECHO_W-1:0]  i_echo_us,
    input  logic                         i_ready,
    output logic                         o_valid,
    output logic                         o_kind,
    output logic [ssog_pkg::ANGLE_W-1:0] o_angle,
    output logic [ssog_pkg::DIST_W-1:0]  o_distance_q4,
    output logic                         o_red_zone,
    output logic                         o_last
);
    import ssog_pkg::*;

    localparam int CW = $clog2(MAX_OBJECT_RECORDS + 1);
    localparam int AW = MAX_OBJECT_RECORDS > 1 ? $clog2(MAX_OBJECT_RECORDS) : 1;

    // Control state.
    logic [DIST_W-1:0]  r_prev, n_prev;
    logic               r_open, n_open;
    logic [DIST_W-1:0]  r_nd, n_nd;
    logic [ANGLE_W-1:0] r_na, n_na;
    logic [MISS_W-1:0]  r_miss, n_miss;
    logic [CW-1:0]      r_count, n_count;
    logic [ANGLE_W-1:0] r_angle, n_angle;
    logic               r_down, n_down;
    logic [CW-1:0]      r_idx, n_idx;
    logic               r_valid, n_valid;

    // Payload registers.
    logic [DIST_W-1:0]  r_raw;
    logic               r_us_nz;
    logic [DIST_W-1:0]  r_d;
    logic               r_raw_ok;
    logic               r_kind;
    logic [ANGLE_W-1:0] r_out_angle;
    logic [DIST_W-1:0]  r_out_dist;
    logic               r_red;
    logic               r_last;

    logic [ECHO_W-1:0]  w_us;
    logic [24:0]        w_prod;
    logic [DIST_W-1:0]  w_hi;
    logic               w_raw_ok;
    logic [20:0]        w_mix;
    logic [DIST_W-1:0]  w_smooth;
    logic               w_in_range;
    logic [DIST_W-1:0]  w_diff;
    logic               w_room;
    logic [2:0]         w_miss_inc;
    logic signed [9:0]  w_next;
    logic               w_end;
    logic [ANGLE_W-1:0] w_new_angle;
    logic               w_new_down;
    logic               w_we;
    logic [REC_W-1:0]   w_rdata;
    logic [DIST_W-1:0]  w_rec_dist;

    // Echo to distance: timeout folds to no echo, then scale by 557/2048.
    assign w_us   = (i_echo_us > ECHO_TIMEOUT_US) ? '0 : i_echo_us;
    assign w_prod = {10'd0, w_us} * 25'(ECHO_SCALE);
    assign w_hi   = {i_max_range_cm, 4'b0000};

    // Raw range check and exponential smoothing against the previous sample.
    assign w_raw_ok = r_us_nz && (r_raw > MIN_DIST_Q4) && (r_raw < w_hi);
    assign w_mix    = 21'(r_raw) * 21'(WEIGHT_NEW) + 21'(r_prev) * 21'(WEIGHT_OLD);
    assign w_smooth = w_mix[20:8];

    // Grouping tests on the smoothed sample.
    assign w_in_range = r_raw_ok && (r_d > MIN_DIST_Q4) && (r_d < w_hi);
    assign w_diff     = (r_d > r_nd) ? (r_d - r_nd) : (r_nd - r_d);
    assign w_room     = r_count < CW'(MAX_OBJECT_RECORDS);
    assign w_miss_inc = {1'b0, r_miss} + 3'd1;

    // Next sweep angle with bounce at the limits.
    always_comb begin
        w_next      = $signed({2'b00, r_angle}) + (r_down ? -10'sd2 : 10'sd2);
        w_end       = 1'b0;
        w_new_angle = w_next[ANGLE_W-1:0];
        w_new_down  = r_down;
        priority if (w_next >= $signed({2'b00, i_max_angle})) begin
            w_new_angle = i_max_angle;
            w_new_down  = 1'b1;
            w_end       = 1'b1;
        end else if (w_next <= $signed({2'b00, i_min_angle})) begin
            w_new_angle = i_min_angle;
            w_new_down  = 1'b0;
            w_end       = 1'b1;
        end else begin
            w_end = 1'b0;
        end
    end

    // State update for each step of the item.
    always_comb begin
        n_prev  = r_prev;
        n_open  = r_open;
        n_nd    = r_nd;
        n_na    = r_na;
        n_miss  = r_miss;
        n_count = r_count;
        n_angle = r_angle;
        n_down  = r_down;
        n_idx   = r_idx;
        w_we    = 1'b0;

        if (i_cmd.smooth) begin
            n_prev = w_raw_ok ? w_smooth : '0;
        end

        if (i_cmd.group) begin
            if (w_in_range) begin
                n_miss = '0;
                if (!r_open) begin
                    n_open = 1'b1;
                    n_nd   = r_d;
                    n_na   = r_angle;
                end else if (w_diff <= GROUP_SPAN_Q4) begin
                    if (r_d < r_nd) begin
                        n_nd = r_d;
                        n_na = r_angle;
                    end
                end else begin
                    // A jump closes the group and starts a new one here.
                    w_we = w_room;
                    n_nd = r_d;
                    n_na = r_angle;
                end
            end else if (r_open) begin
                if (w_miss_inc >= 3'(MISS_TOLERANCE)) begin
                    w_we   = w_room;
                    n_open = 1'b0;
                    n_miss = '0;
                end else begin
                    n_miss = w_miss_inc[MISS_W-1:0];
                end
            end
        end

        if (i_cmd.sweep) begin
            n_angle = w_new_angle;
            n_down  = w_new_down;
            // At a sweep end the open group is stored if there is room.
            if (w_end && r_open && w_room) begin
                w_we   = 1'b1;
                n_open = 1'b0;
            end
        end

        if (w_we) begin
            n_count = r_count + CW'(1);
        end

        if (i_cmd.clr_idx) begin
            n_idx = '0;
        end else if (i_cmd.obj) begin
            n_idx = r_idx + CW'(1);
        end

        if (i_cmd.end_clear) begin
            n_count = '0;
            n_miss  = '0;
        end
    end

    // Output word register.
    always_comb begin
        if (i_cmd.obj || i_cmd.pos) begin
            n_valid = 1'b1;
        end else if (i_ready) begin
            n_valid = 1'b0;
        end else begin
            n_valid = r_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev  <= '0;
            r_open  <= 1'b0;
            r_nd    <= '0;
            r_na    <= '0;
            r_miss  <= '0;
            r_count <= '0;
            r_angle <= '0;
            r_down  <= 1'b0;
            r_idx   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_prev  <= n_prev;
            r_open  <= n_open;
            r_nd    <= n_nd;
            r_na    <= n_na;
            r_miss  <= n_miss;
            r_count <= n_count;
            r_angle <= n_angle;
            r_down  <= n_down;
            r_idx   <= n_idx;
            r_valid <= n_valid;
        end
    end

    assign w_rec_dist = w_rdata[DIST_W-1:0];

    // Pipeline payload and the output word fields.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_raw   <= w_prod[23:11];
            r_us_nz <= w_us != '0;
        end
        if (i_cmd.smooth) begin
            r_d      <= w_raw_ok ? w_smooth : r_raw;
            r_raw_ok <= w_raw_ok;
        end
        if (i_cmd.obj) begin
            r_kind      <= KIND_OBJ;
            r_out_angle <= w_rdata[REC_W-1:DIST_W];
            r_out_dist  <= w_rec_dist;
            r_red       <= i_alert_enable && (w_rec_dist < {i_red_zone_cm, 4'b0000});
            r_last      <= 1'b0;
        end else if (i_cmd.pos) begin
            r_kind      <= KIND_POS;
            r_out_angle <= i_cmd.park ? PARK_ANGLE : r_angle;
            r_out_dist  <= '0;
            r_red       <= 1'b0;
            r_last      <= 1'b1;
        end
    end

    // Object store.
    ssog_ram #(
        .WIDTH (REC_W),
        .DEPTH (MAX_OBJECT_RECORDS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata ({r_na, r_nd}),
        .i_re    (i_cmd.rd),
        .i_raddr (r_idx[AW-1:0]),
        .o_rdata (w_rdata)
    );

    assign o_sts.sweep_end = w_end;
    assign o_sts.idx_lt    = r_idx < r_count;
    assign o_sts.out_free  = !r_valid || i_ready;

    assign o_valid       = r_valid;
    assign o_kind        = r_kind;
    assign o_angle       = r_out_angle;
    assign o_distance_q4 = r_out_dist;
    assign o_red_zone    = r_red;
    assign o_last        = r_last;
endmodule

### hw/rtl/ssog_ctrl.sv
module ssog_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic              i_system_enable,
    input  ssog_pkg::t_dp_sts i_sts,
    output ssog_pkg::t_dp_cmd o_cmd
);
    import ssog_pkg::*;

    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_SMOOTH = 8'b0000_0010,
        S_GROUP  = 8'b0000_0100,
        S_SWEEP  = 8'b0000_1000,
        S_READ   = 8'b0001_0000,
        S_OBJ    = 8'b0010_0000,
        S_POS    = 8'b0100_0000,
        S_PARK   = 8'b1000_0000
    } t_state;

    t_state r_state, n_state;

    // Sequencing of one item and of the object dump at a sweep end.
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = i_system_enable ? S_SMOOTH : S_PARK;
                end
            end
            S_SMOOTH: begin
                o_cmd.smooth = 1'b1;
                n_state      = S_GROUP;
            end
            S_GROUP: begin
                o_cmd.group = 1'b1;
                n_state     = S_SWEEP;
            end
            S_SWEEP: begin
                o_cmd.sweep   = 1'b1;
                o_cmd.clr_idx = 1'b1;
                n_state       = i_sts.sweep_end ? S_READ : S_POS;
            end
            S_READ: begin
                if (i_sts.idx_lt) begin
                    o_cmd.rd = 1'b1;
                    n_state  = S_OBJ;
                end else begin
                    o_cmd.end_clear = 1'b1;
                    n_state         = S_POS;
                end
            end
            S_OBJ: begin
                if (i_sts.out_free) begin
                    o_cmd.obj = 1'b1;
                    n_state   = S_READ;
                end
            end
            S_POS: begin
                if (i_sts.out_free) begin
                    o_cmd.pos = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            S_PARK: begin
                if (i_sts.out_free) begin
                    o_cmd.pos  = 1'b1;
                    o_cmd.park = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end
endmodule
